/* src/flid_pkg.sv */
// ============================================================================
// flid_pkg
// Shared types and constants for the flash log item directory.
// ============================================================================
package flid_pkg;

    localparam int ID_W   = 8;
    localparam int ADDR_W = 24;
    localparam int LEN_W  = 24;
    localparam int BLK_W  = 8;
    localparam int OP_W   = 2;
    localparam int ENT_W  = ID_W + ADDR_W + LEN_W;

    localparam logic [ID_W-1:0] ID_EMPTY = 8'hFF;

    typedef enum logic [OP_W-1:0] {
        OP_RECORD     = 2'd0,
        OP_LOOKUP     = 2'd1,
        OP_INVALIDATE = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_TAIL  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // Entry layout, lowest bits first: id, address, length.
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] addr;
        logic [ID_W-1:0]   id;
    } t_entry;

endpackage

/* src/flash_log_item_directory.sv */
// ============================================================================
// flash_log_item_directory
// Directory of items in a flash log: record, lookup and erase-block invalidate
// over a single-port-write, registered-read entry memory.
// ============================================================================
// One transaction is handled at a time. Entries live in one memory read one
// entry per cycle with a registered read; the scan is pipelined so a new
// address is issued every cycle. Record fills the first slot that is empty or
// holds its id, else evicts the oldest: the shift toward the front copies
// every later entry through the memory port. Lookup scans from the last slot
// down, invalidate scans every slot, an unused operation code goes straight to
// the result. A new transaction is taken while the previous result still waits
// in the output register. Per-entry valid flops make the whole directory read
// as empty right after reset; no clearing pass is run.
module flash_log_item_directory #(
    parameter int ENTRY_COUNT = 35
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // item_id, item_address, item_length, erase_block
    input  logic [1:0]  i_s_axis_tuser,  // operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // found_address, found_length
    output logic [1:0]  o_m_axis_tuser   // found, evicted_oldest
);
    import flid_pkg::*;

    localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam logic [IW-1:0] LAST = IW'(ENTRY_COUNT - 1);

    // entry memory and valid bits
    t_entry                 r_mem [ENTRY_COUNT];
    t_entry                 r_mem_q;
    logic                   r_q_vld;
    logic [ENTRY_COUNT-1:0] r_vld;

    t_state            r_state, n_state;
    logic              r_issue, n_issue;
    logic [IW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_ev, n_ev;
    logic [IW-1:0]     r_ev_idx, n_ev_idx;
    t_op               r_op, n_op;
    logic [ID_W-1:0]   r_id, n_id;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [BLK_W-1:0]  r_blk, n_blk;
    logic              r_res_found, n_res_found;
    logic              r_res_evict, n_res_evict;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic [LEN_W-1:0]  r_res_len, n_res_len;
    logic              r_out_vld, n_out_vld;
    logic              r_out_found, n_out_found;
    logic              r_out_evict, n_out_evict;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;
    logic [LEN_W-1:0]  r_out_len, n_out_len;

    logic          w_in_acc;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_entry        w_wdata;
    logic          w_vld_set;
    logic          w_vld_clr;
    t_entry        w_d;
    t_entry        w_new;
    logic          w_down;
    logic          w_issue_end;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid & o_s_axis_tready;
    assign w_d             = r_q_vld ? r_mem_q : t_entry'('1);
    assign w_new           = '{len: r_len, addr: r_addr, id: r_id};
    assign w_down          = (r_op == OP_LOOKUP);
    assign w_issue_end     = w_down ? (r_rd_idx == '0) : (r_rd_idx == LAST);

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_len, r_out_addr};
    assign o_m_axis_tuser  = {r_out_evict, r_out_found};

    always_comb begin
        n_state     = r_state;
        n_issue     = r_issue;
        n_rd_idx    = r_rd_idx;
        n_ev        = r_ev;
        n_ev_idx    = r_ev_idx;
        n_op        = r_op;
        n_id        = r_id;
        n_addr      = r_addr;
        n_len       = r_len;
        n_blk       = r_blk;
        n_res_found = r_res_found;
        n_res_evict = r_res_evict;
        n_res_addr  = r_res_addr;
        n_res_len   = r_res_len;
        n_out_vld   = r_out_vld;
        n_out_found = r_out_found;
        n_out_evict = r_out_evict;
        n_out_addr  = r_out_addr;
        n_out_len   = r_out_len;
        w_we        = 1'b0;
        w_waddr     = r_ev_idx;
        w_wdata     = w_d;
        w_vld_set   = 1'b0;
        w_vld_clr   = 1'b0;

        if (r_out_vld && i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        // read issue, shared by the scan and the shift
        if ((r_state == S_SCAN) || (r_state == S_SHIFT)) begin
            n_ev     = r_issue;
            n_ev_idx = r_rd_idx;
            if (r_issue) begin
                if (w_issue_end) begin
                    n_issue = 1'b0;
                end else if (w_down) begin
                    n_rd_idx = r_rd_idx - IW'(1);
                end else begin
                    n_rd_idx = r_rd_idx + IW'(1);
                end
            end
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op        = t_op'(i_s_axis_tuser);
                    n_id        = i_s_axis_tdata[7:0];
                    n_addr      = i_s_axis_tdata[31:8];
                    n_len       = i_s_axis_tdata[55:32];
                    n_blk       = i_s_axis_tdata[63:56];
                    n_res_found = 1'b0;
                    n_res_evict = 1'b0;
                    n_res_addr  = '0;
                    n_res_len   = '0;
                    n_ev        = 1'b0;
                    case (t_op'(i_s_axis_tuser))
                        OP_RECORD, OP_INVALIDATE: begin
                            n_state  = S_SCAN;
                            n_issue  = 1'b1;
                            n_rd_idx = '0;
                        end
                        OP_LOOKUP: begin
                            n_state  = S_SCAN;
                            n_issue  = 1'b1;
                            n_rd_idx = LAST;
                        end
                        default: begin
                            n_state = S_DONE;
                            n_issue = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_ev) begin
                    case (r_op)
                        OP_RECORD: begin
                            if ((w_d.id == ID_EMPTY) || (w_d.id == r_id)) begin
                                w_we      = 1'b1;
                                w_wdata   = w_new;
                                w_vld_set = 1'b1;
                                n_state   = S_DONE;
                                n_issue   = 1'b0;
                                n_ev      = 1'b0;
                            end else if (r_ev_idx == LAST) begin
                                n_state  = S_SHIFT;
                                n_issue  = 1'b1;
                                n_rd_idx = IW'(1);
                                n_ev     = 1'b0;
                            end
                        end
                        OP_LOOKUP: begin
                            if (w_d.id == r_id) begin
                                n_res_found = 1'b1;
                                n_res_addr  = w_d.addr;
                                n_res_len   = w_d.len;
                                n_state     = S_DONE;
                                n_issue     = 1'b0;
                                n_ev        = 1'b0;
                            end else if (r_ev_idx == '0) begin
                                n_state = S_DONE;
                                n_ev    = 1'b0;
                            end
                        end
                        OP_INVALIDATE: begin
                            if ((w_d.id != ID_EMPTY) && (w_d.addr[23:16] == r_blk)) begin
                                w_vld_clr = 1'b1;
                            end
                            if (r_ev_idx == LAST) begin
                                n_state = S_DONE;
                                n_ev    = 1'b0;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                            n_issue = 1'b0;
                            n_ev    = 1'b0;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                if (r_ev) begin
                    w_we      = 1'b1;
                    w_waddr   = r_ev_idx - IW'(1);
                    w_wdata   = w_d;
                    w_vld_set = 1'b1;
                    if (r_ev_idx == LAST) begin
                        n_state = S_TAIL;
                        n_ev    = 1'b0;
                    end
                end
            end
            S_TAIL: begin
                w_we        = 1'b1;
                w_waddr     = LAST;
                w_wdata     = w_new;
                w_vld_set   = 1'b1;
                n_res_evict = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out_vld   = 1'b1;
                    n_out_found = r_res_found;
                    n_out_evict = r_res_evict;
                    n_out_addr  = r_res_addr;
                    n_out_len   = r_res_len;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_issue = 1'b0;
                n_ev    = 1'b0;
            end
        endcase
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_mem_q <= r_mem[r_rd_idx];
        r_q_vld <= r_vld[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_vld_set) begin
            r_vld[w_waddr] <= 1'b1;
        end else if (w_vld_clr) begin
            r_vld[w_waddr] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issue   <= 1'b0;
            r_ev      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issue   <= n_issue;
            r_ev      <= n_ev;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_ev_idx    <= n_ev_idx;
        r_op        <= n_op;
        r_id        <= n_id;
        r_addr      <= n_addr;
        r_len       <= n_len;
        r_blk       <= n_blk;
        r_res_found <= n_res_found;
        r_res_evict <= n_res_evict;
        r_res_addr  <= n_res_addr;
        r_res_len   <= n_res_len;
        r_out_found <= n_out_found;
        r_out_evict <= n_out_evict;
        r_out_addr  <= n_out_addr;
        r_out_len   <= n_out_len;
    end

endmodule

/* bench/tb_top.sv */
// ============================================================================
// tb_top
// Testbench for flash_log_item_directory: record, lookup and invalidate.
// ============================================================================
// A queue of directory operations feeds a stream driver. Each accepted
// transaction runs through a local directory predictor. The expected result
// goes into a queue, and a monitor compares every output transaction against
// it field by field. Both sides idle at random, and there is one long output
// stall and two drain pauses.
module tb_top;
    import flid_pkg::*;

    localparam int SLOTS          = 35;
    localparam int IDLE_LIMIT     = 4000;
    localparam int TAIL_CYCLES    = 100;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int LONG_STALL     = 600;
    localparam int STALL_AT_INPUT = 300;

    typedef struct {
        t_op         op;
        logic [7:0]  id;
        logic [23:0] addr;
        logic [23:0] len;
        logic [7:0]  blk;
        bit          drain;
    } dir_req_t;

    typedef struct {
        logic        found;
        logic [23:0] faddr;
        logic [23:0] flen;
        logic        evicted;
    } dir_resp_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        o_m_axis_tvalid;
    logic        m_ready = 1'b0;
    logic [47:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    flash_log_item_directory #(.ENTRY_COUNT(SLOTS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),  // item_id, item_address, item_length, erase_block
        .i_s_axis_tuser  (s_user),  // operation
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // found_address, found_length
        .o_m_axis_tuser  (o_m_axis_tuser)   // found, evicted_oldest
    );

    // Directory model state
    logic [7:0]  slot_id   [SLOTS];
    logic [23:0] slot_addr [SLOTS];
    logic [23:0] slot_len  [SLOTS];

    dir_req_t  pending_items[$];
    dir_resp_t expected_results[$];
    dir_req_t  inflight_req;

    bit s_took = 1'b0;
    bit sender_burst = 1'b0;
    bit receiver_burst = 1'b0;
    bit long_hold_done = 1'b0;
    int gap_left = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int input_count = 0;
    int error_count = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic dir_resp_t apply_directory_op(dir_req_t r);
        dir_resp_t res;
        bit placed;
        res = '{found: 1'b0, faddr: '0, flen: '0, evicted: 1'b0};
        placed = 1'b0;
        case (r.op)
            OP_RECORD: begin
                for (int k = 0; k < SLOTS && !placed; k++) begin
                    if (slot_id[k] == ID_EMPTY || slot_id[k] == r.id) begin
                        slot_id[k]   = r.id;
                        slot_addr[k] = r.addr;
                        slot_len[k]  = r.len;
                        placed = 1'b1;
                    end
                end
                if (!placed) begin
                    for (int k = 0; k < SLOTS - 1; k++) begin
                        slot_id[k]   = slot_id[k+1];
                        slot_addr[k] = slot_addr[k+1];
                        slot_len[k]  = slot_len[k+1];
                    end
                    slot_id[SLOTS-1]   = r.id;
                    slot_addr[SLOTS-1] = r.addr;
                    slot_len[SLOTS-1]  = r.len;
                    res.evicted = 1'b1;
                end
            end
            OP_LOOKUP: begin
                for (int k = SLOTS - 1; k >= 0 && !res.found; k--) begin
                    if (slot_id[k] == r.id) begin
                        res.found = 1'b1;
                        res.faddr = slot_addr[k];
                        res.flen  = slot_len[k];
                    end
                end
            end
            OP_INVALIDATE: begin
                for (int k = 0; k < SLOTS; k++) begin
                    if (slot_id[k] != ID_EMPTY && slot_addr[k][23:16] == r.blk) begin
                        slot_id[k]   = ID_EMPTY;
                        slot_addr[k] = '1;
                        slot_len[k]  = '1;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic add_item(t_op op, logic [7:0] id, logic [23:0] addr,
                            logic [23:0] len, logic [7:0] blk, bit drain);
        dir_req_t r;
        r = '{op: op, id: id, addr: addr, len: len, blk: blk, drain: drain};
        pending_items.push_back(r);
    endtask

    function automatic logic [7:0] pick_block();
        logic [7:0] hot_blocks [4];
        hot_blocks = '{8'h00, 8'h01, 8'h80, 8'hFF};
        if ($urandom_range(0, 99) < 80)
            return hot_blocks[$urandom_range(0, 3)];
        return 8'($urandom);
    endfunction

    task automatic add_random_item(int pool, bit drain);
        t_op        op;
        logic [7:0] id;
        logic [23:0] addr;
        int r;
        r = $urandom_range(0, 99);
        if (pool == 40) begin
            op = (r < 60) ? OP_RECORD : (r < 95) ? OP_LOOKUP : (r < 97) ? OP_INVALIDATE
                                                                        : OP_NONE;
        end else begin
            op = (r < 40) ? OP_RECORD : (r < 75) ? OP_LOOKUP : (r < 95) ? OP_INVALIDATE
                                                                        : OP_NONE;
        end
        if ($urandom_range(0, 99) < 3)
            id = ID_EMPTY;
        else if (pool == 256)
            id = 8'($urandom);
        else
            id = 8'($urandom_range(0, pool - 1));
        if ($urandom_range(0, 99) < 70)
            addr = {pick_block(), 16'($urandom)};
        else
            addr = 24'($urandom);
        add_item(op, id, addr, 24'($urandom), pick_block(), drain);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_result();
        dir_resp_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with none pending", o_m_axis_tdata[23:0], '0);
        end else begin
            want = expected_results.pop_front();
            if (o_m_axis_tuser[0] !== want.found)
                report_mismatch("found", 24'(o_m_axis_tuser[0]), 24'(want.found));
            if (o_m_axis_tdata[23:0] !== want.faddr)
                report_mismatch("found_address", o_m_axis_tdata[23:0], want.faddr);
            if (o_m_axis_tdata[47:24] !== want.flen)
                report_mismatch("found_length", o_m_axis_tdata[47:24], want.flen);
            if (o_m_axis_tuser[1] !== want.evicted)
                report_mismatch("evicted_oldest", 24'(o_m_axis_tuser[1]),
                                24'(want.evicted));
        end
    endtask

    // Sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_took) begin
            s_valid <= 1'b1;
        end else if (gap_left != 0) begin
            s_valid  <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain && expected_results.size() != 0)) begin
            inflight_req = pending_items.pop_front();
            s_data   <= {inflight_req.blk, inflight_req.len, inflight_req.addr,
                         inflight_req.id};
            s_user   <= inflight_req.op;
            s_valid  <= 1'b1;
            gap_left <= sender_burst ? 0 : pick_gap();
            if ($urandom_range(0, 99) == 0)
                sender_burst = !sender_burst;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (input_count >= STALL_AT_INPUT && !long_hold_done) begin
            m_ready        <= 1'b0;
            hold_left      <= LONG_STALL;
            long_hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!receiver_burst && $urandom_range(0, 99) < 20) begin
            m_ready   <= 1'b0;
            hold_left <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                      : $urandom_range(10, 100);
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 199) == 0)
                receiver_burst = !receiver_burst;
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_took      <= 1'b0;
            idle_cycles <= 0;
        end else begin
            s_took <= s_valid && o_s_axis_tready;
            if (s_valid && o_s_axis_tready) begin
                expected_results.push_back(apply_directory_op(inflight_req));
                input_count <= input_count + 1;
            end
            if (o_m_axis_tvalid && m_ready)
                check_result();
            if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog
    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $display("tb_top failed");
        $finish;
    end

    initial begin
        int pool;
        int pools [3];
        pools = '{4, 40, 256};
        pool = 4;
        for (int k = 0; k < SLOTS; k++) begin
            slot_id[k]   = ID_EMPTY;
            slot_addr[k] = '1;
            slot_len[k]  = '1;
        end

        // Empty directory, unused code, zero entry, empty-id record, invalidates
        add_item(OP_LOOKUP,     8'h00,    24'h000000, 24'h000000, 8'h00, 1'b0);
        add_item(OP_LOOKUP,     ID_EMPTY, 24'h000000, 24'h000000, 8'h00, 1'b0);
        add_item(OP_NONE,       8'h5A,    24'hFFFFFF, 24'hFFFFFF, 8'hFF, 1'b0);
        add_item(OP_RECORD,     8'h00,    24'h000000, 24'h000000, 8'h00, 1'b0);
        add_item(OP_LOOKUP,     8'h00,    24'h000000, 24'h000000, 8'h00, 1'b0);
        add_item(OP_RECORD,     ID_EMPTY, 24'h123456, 24'hABCDEF, 8'h00, 1'b0);
        add_item(OP_LOOKUP,     ID_EMPTY, 24'h000000, 24'h000000, 8'h00, 1'b0);
        add_item(OP_RECORD,     8'hFE,    24'hFFFFFF, 24'hFFFFFF, 8'h00, 1'b0);
        add_item(OP_LOOKUP,     8'hFE,    24'h000000, 24'h000000, 8'h00, 1'b0);
        add_item(OP_RECORD,     8'h00,    24'h01ABCD, 24'h000001, 8'h00, 1'b0);
        add_item(OP_LOOKUP,     8'h00,    24'h000000, 24'h000000, 8'h00, 1'b0);
        add_item(OP_INVALIDATE, 8'h00,    24'h000000, 24'h000000, 8'h12, 1'b0);
        add_item(OP_LOOKUP,     ID_EMPTY, 24'h000000, 24'h000000, 8'h00, 1'b0);
        add_item(OP_INVALIDATE, 8'h00,    24'h000000, 24'h000000, 8'hFF, 1'b0);
        add_item(OP_LOOKUP,     8'hFE,    24'h000000, 24'h000000, 8'h00, 1'b0);
        add_item(OP_INVALIDATE, 8'hFF,    24'hFFFFFF, 24'hFFFFFF, 8'h01, 1'b0);
        add_item(OP_LOOKUP,     8'h00,    24'h000000, 24'h000000, 8'h00, 1'b0);
        add_item(OP_NONE,       8'h00,    24'h000000, 24'h000000, 8'h00, 1'b0);
        add_item(OP_LOOKUP,     8'h77,    24'h000000, 24'h000000, 8'h00, 1'b1);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0)
                pool = pools[$urandom_range(0, 2)];
            add_random_item(pool, i == RANDOM_ITEMS / 2);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_items.size() != 0 || s_valid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

/* filelist.f */
src/flid_pkg.sv
src/flash_log_item_directory.sv
bench/tb_top.sv
